[rtl/core/lds_pkg.sv]
package lds_pkg;

  // Fractional bits of the Q16.16 coordinates
  localparam int FRAC = 16;
  // Normalised light vector magnitude width (top bit set at bit AW-1)
  localparam int AW = 31;
  // Surface normal width, signed
  localparam int NW = 50;
  // Length (square root) width
  localparam int LW = 32;
  // Square root digits, one per stage
  localparam int SQ_STAGES = 32;
  // Divider stages: one for the leading quotient bit, then one per bit
  localparam int DIV_STAGES = AW;

  localparam logic [16:0] BRIGHT_RESET = 17'd65536;
  localparam logic [23:0] RGB_RESET    = 24'hFFFFFF;

  // Channel value clips at 255 once the scaled product reaches 255 * 256
  localparam logic [31:0] CLIP_LIMIT = 32'd65280;
  // floor(w / 255) = (w * 32897) >> 23 for w below CLIP_LIMIT
  localparam logic [15:0] DIV255_MUL = 16'd32897;
  localparam int          DIV255_SH  = 23;

  typedef enum logic [2:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_BRIGHT  = 3'd3,
    REG_RGB     = 3'd4
  } lds_reg_t;

  typedef enum logic [1:0] {
    OBJ_PLANE   = 2'd0,
    OBJ_SPHERE  = 2'd1,
    OBJ_CYL     = 2'd2,
    OBJ_UNKNOWN = 2'd3
  } lds_obj_t;

  typedef struct packed {
    logic adv;
    logic valid;
  } lds_ctl_t;

  typedef struct packed {
    logic [2:0][AW-1:0] a;
    logic [2:0]         dsgn;
    logic [2:0][NW-1:0] n;
    logic               black;
    logic [23:0]        orgb;
  } lds_side_t;

endpackage

[rtl/core/lds_in_if.sv]
interface lds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         object_type;
  logic [23:0]        object_rgb;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] surface_x;
  logic signed [31:0] surface_y;
  logic signed [31:0] surface_z;

  modport source (
    output valid, object_type, object_rgb, hit_x, hit_y, hit_z,
    center_x, center_y, center_z, surface_x, surface_y, surface_z,
    input  ready
  );
  modport sink (
    input  valid, object_type, object_rgb, hit_x, hit_y, hit_z,
    center_x, center_y, center_z, surface_x, surface_y, surface_z,
    output ready
  );
endinterface

[rtl/core/lds_out_if.sv]
interface lds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/core/lds_cfg_if.sv]
interface lds_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/lds_isqrt.sv]
module lds_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  lds_pkg::lds_ctl_t  ctl,
  input  logic [63:0]        x_in,
  input  lds_pkg::lds_side_t side_in,
  output logic               out_valid,
  output logic [lds_pkg::LW-1:0] root_out,
  output lds_pkg::lds_side_t side_out
);

  localparam int NS = lds_pkg::SQ_STAGES;

  logic [NS-1:0]        v_r;
  logic [34:0]          rem_r  [NS];
  logic [lds_pkg::LW-1:0] root_r [NS];
  logic [63:0]          x_r    [NS];
  lds_pkg::lds_side_t   side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic               vin;
    logic [34:0]        rem_in;
    logic [lds_pkg::LW-1:0] root_in;
    logic [63:0]        x_cur;
    lds_pkg::lds_side_t side_cur;
    logic [36:0]        cand;
    logic [36:0]        trial;

    if (k == 0) begin : g_first
      assign vin      = ctl.valid;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign x_cur    = x_in;
      assign side_cur = side_in;
    end else begin : g_next
      assign vin      = v_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
      assign x_cur    = x_r[k-1];
      assign side_cur = side_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cand  = {rem_in, x_cur[63:62]};
    assign trial = {3'b000, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.adv) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        if (cand >= trial) begin
          rem_r[k]  <= 35'(cand - trial);
          root_r[k] <= {root_in[lds_pkg::LW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cand[34:0];
          root_r[k] <= {root_in[lds_pkg::LW-2:0], 1'b0};
        end
        x_r[k]    <= {x_cur[61:0], 2'b00};
        side_r[k] <= side_cur;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign root_out  = root_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

[rtl/core/lds_div3.sv]
module lds_div3 (
  input  logic               clk,
  input  logic               rst_n,
  input  lds_pkg::lds_ctl_t  ctl,
  input  logic [lds_pkg::LW-1:0] len_in,
  input  lds_pkg::lds_side_t side_in,
  output logic               out_valid,
  output logic [2:0][lds_pkg::AW-1:0] q_out,
  output lds_pkg::lds_side_t side_out
);

  localparam int NS = lds_pkg::DIV_STAGES;
  localparam int LW = lds_pkg::LW;
  localparam int AW = lds_pkg::AW;

  logic [NS-1:0]          v_r;
  logic [2:0][LW-1:0]     rem_r  [NS];
  logic [2:0][AW-1:0]     q_r    [NS];
  logic [LW-1:0]          len_r  [NS];
  lds_pkg::lds_side_t     side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic               vin;
    logic [LW-1:0]      len_cur;
    lds_pkg::lds_side_t side_cur;
    logic [2:0][LW-1:0] rem_nxt;
    logic [2:0][AW-1:0] q_nxt;

    if (k == 0) begin : g_first
      // leading quotient bit: a against len
      assign vin      = ctl.valid;
      assign len_cur  = len_in;
      assign side_cur = side_in;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          if (LW'(side_in.a[i]) >= len_in) begin
            rem_nxt[i] = LW'(side_in.a[i]) - len_in;
            q_nxt[i]   = AW'(1);
          end else begin
            rem_nxt[i] = LW'(side_in.a[i]);
            q_nxt[i]   = '0;
          end
        end
      end
    end else begin : g_next
      // shift in a zero, subtract len where it fits
      logic [2:0][LW:0] cand;
      assign vin      = v_r[k-1];
      assign len_cur  = len_r[k-1];
      assign side_cur = side_r[k-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          cand[i] = {rem_r[k-1][i], 1'b0};
          if (cand[i] >= {1'b0, len_r[k-1]}) begin
            rem_nxt[i] = LW'(cand[i] - {1'b0, len_r[k-1]});
            q_nxt[i]   = {q_r[k-1][i][AW-2:0], 1'b1};
          end else begin
            rem_nxt[i] = cand[i][LW-1:0];
            q_nxt[i]   = {q_r[k-1][i][AW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.adv) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        len_r[k]  <= len_cur;
        side_r[k] <= side_cur;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign q_out     = q_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

[rtl/core/lambert_diffuse_shader.sv]
// Lambert diffuse shader for one point light. Each input word is one surface
// hit (object type, colour, hit point, object centre, plane normal or cylinder
// axis, all Q16.16); each output word is its diffuse red, green and blue. The
// pipeline takes one word per clock while the output does not stall and gives
// one result word per input word, in order; most of its depth is the 32-stage
// square root and the 31-stage divider that normalise the light vector. A
// stall on the output freezes the whole pipeline: in_ch.ready follows the
// output register being empty or taken. Light position, brightness and colour
// are written through cfg_ch (always ready) and must only change while no
// word is in flight. Light on the hit point, an unknown object type or a
// surface facing away gives black.
module lambert_diffuse_shader (
  input  logic clk,
  input  logic rst_n,
  lds_in_if.sink    in_ch,
  lds_out_if.source out_ch,
  lds_cfg_if.sink   cfg_ch
);

  localparam int FRAC = lds_pkg::FRAC;
  localparam int AW   = lds_pkg::AW;
  localparam int NW   = lds_pkg::NW;
  localparam int MSBT = AW - 1;          // target top bit after block scaling
  localparam int PW   = 65 - FRAC;       // cylinder projection term width
  localparam int TW   = PW + 3;          // projection sum width, signed
  localparam int QW   = 64 - FRAC;       // axis * t term width
  localparam int NL   = 25;              // low slice of |n|
  localparam int NH   = NW - 1 - NL;     // high slice of |n|
  localparam int PRW  = NW - 1 + AW;     // |n| * u width
  localparam int SW   = PRW + 3;         // dot product sum width, signed
  localparam int DW   = SW - 1;          // positive dot product width
  localparam int BW   = DW + 17;         // dot * brightness width
  localparam int IS   = FRAC + 14;       // intensity shift
  localparam int IW   = 48;              // intensity width below saturation

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? 33'(~v + 33'd1) : v;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  // ---------------------------------------------------------------- config
  logic [2:0][31:0] light_r;
  logic [16:0]      bright_r;
  logic [23:0]      lrgb_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r  <= '0;
      bright_r <= lds_pkg::BRIGHT_RESET;
      lrgb_r   <= lds_pkg::RGB_RESET;
    end else if (cfg_ch.valid) begin
      case (lds_pkg::lds_reg_t'(cfg_ch.index))
        lds_pkg::REG_LIGHT_X: light_r[0] <= cfg_ch.data;
        lds_pkg::REG_LIGHT_Y: light_r[1] <= cfg_ch.data;
        lds_pkg::REG_LIGHT_Z: light_r[2] <= cfg_ch.data;
        lds_pkg::REG_BRIGHT:  bright_r   <= cfg_ch.data[16:0];
        lds_pkg::REG_RGB:     lrgb_r     <= cfg_ch.data[23:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // One enable for every stage: advance whenever the output register is
  // empty or its word is being taken this cycle.
  logic out_valid_r;
  logic adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic [2:0][31:0] hit_w, cen_w, srf_w;

  always_comb begin
    hit_w[0] = in_ch.hit_x;     hit_w[1] = in_ch.hit_y;     hit_w[2] = in_ch.hit_z;
    cen_w[0] = in_ch.center_x;  cen_w[1] = in_ch.center_y;  cen_w[2] = in_ch.center_z;
    srf_w[0] = in_ch.surface_x; srf_w[1] = in_ch.surface_y; srf_w[2] = in_ch.surface_z;
  end

  // ---------------------------------------------------------------- stage 1
  // Light vector d = light - hit and oc = hit - centre, both exact in 33 bits.
  logic                v_s1_r;
  logic [2:0][32:0]    d_s1_r, oc_s1_r;
  logic [2:0][31:0]    srf_s1_r;
  lds_pkg::lds_obj_t   typ_s1_r;
  logic [23:0]         orgb_s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_s1_r[i]  <= 33'($signed(light_r[i])) - 33'($signed(hit_w[i]));
        oc_s1_r[i] <= 33'($signed(hit_w[i])) - 33'($signed(cen_w[i]));
      end
      srf_s1_r  <= srf_w;
      typ_s1_r  <= lds_pkg::lds_obj_t'(in_ch.object_type);
      orgb_s1_r <= in_ch.object_rgb;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Magnitudes of d, black for zero vector or unknown type, and the cylinder
  // projection terms |oc_i * axis_i| >> FRAC.
  logic                v_s2_r;
  logic [2:0][32:0]    dmag_s2_r, oc_s2_r;
  logic [2:0]          dsgn_s2_r, psgn_s2_r;
  logic [2:0][PW-1:0]  p_s2_r;
  logic [2:0][31:0]    srf_s2_r;
  logic                black_s2_r;
  lds_pkg::lds_obj_t   typ_s2_r;
  logic [23:0]         orgb_s2_r;
  logic [2:0][64:0]    cp_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cp_nxt[i] = 65'(abs33(oc_s1_r[i])) * 65'(abs32(srf_s1_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dmag_s2_r[i] <= abs33(d_s1_r[i]);
        dsgn_s2_r[i] <= d_s1_r[i][32];
        p_s2_r[i]    <= cp_nxt[i][64:FRAC];
        psgn_s2_r[i] <= oc_s1_r[i][32] ^ srf_s1_r[i][31];
      end
      black_s2_r <= (d_s1_r == '0) || (typ_s1_r == lds_pkg::OBJ_UNKNOWN);
      oc_s2_r    <= oc_s1_r;
      srf_s2_r   <= srf_s1_r;
      typ_s2_r   <= typ_s1_r;
      orgb_s2_r  <= orgb_s1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Projection t, saturated to 32 bits; block scale from the top set bit of
  // the OR of the magnitudes (same position as that of the largest).
  logic                v_s3_r;
  logic [31:0]         t_s3_r;
  logic                rsh_s3_r;
  logic [4:0]          amt_s3_r;
  logic [2:0][32:0]    dmag_s3_r, oc_s3_r;
  logic [2:0][31:0]    srf_s3_r;
  logic [2:0]          dsgn_s3_r;
  logic                black_s3_r;
  lds_pkg::lds_obj_t   typ_s3_r;
  logic [23:0]         orgb_s3_r;
  logic [TW-1:0]       tsum_nxt;
  logic [31:0]         t_nxt;
  logic [32:0]         orv_nxt;
  logic [5:0]          pos_nxt;
  logic                rsh_nxt;
  logic [4:0]          amt_nxt;

  always_comb begin
    tsum_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (psgn_s2_r[i]) tsum_nxt = tsum_nxt - TW'(p_s2_r[i]);
      else              tsum_nxt = tsum_nxt + TW'(p_s2_r[i]);
    end
    if (tsum_nxt[TW-1:31] != '0 && tsum_nxt[TW-1:31] != '1) begin
      t_nxt = tsum_nxt[TW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      t_nxt = tsum_nxt[31:0];
    end
  end

  always_comb begin
    orv_nxt = dmag_s2_r[0] | dmag_s2_r[1] | dmag_s2_r[2];
    pos_nxt = '0;
    for (int b = 0; b < 33; b++) begin
      if (orv_nxt[b]) pos_nxt = 6'(b);
    end
    rsh_nxt = pos_nxt > 6'(MSBT);
    amt_nxt = rsh_nxt ? 5'(pos_nxt - 6'(MSBT)) : 5'(6'(MSBT) - pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_s3_r     <= t_nxt;
      rsh_s3_r   <= rsh_nxt;
      amt_s3_r   <= amt_nxt;
      dmag_s3_r  <= dmag_s2_r;
      dsgn_s3_r  <= dsgn_s2_r;
      black_s3_r <= black_s2_r;
      oc_s3_r    <= oc_s2_r;
      srf_s3_r   <= srf_s2_r;
      typ_s3_r   <= typ_s2_r;
      orgb_s3_r  <= orgb_s2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Apply the block scale (right shifts truncate); axis * t term.
  logic                v_s4_r;
  logic [2:0][AW-1:0]  a_s4_r;
  logic [2:0][QW-1:0]  q_s4_r;
  logic [2:0]          qsgn_s4_r, dsgn_s4_r;
  logic [2:0][32:0]    oc_s4_r;
  logic [2:0][31:0]    srf_s4_r;
  logic                black_s4_r;
  lds_pkg::lds_obj_t   typ_s4_r;
  logic [23:0]         orgb_s4_r;
  logic [2:0][63:0]    shw_nxt, qp_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shw_nxt[i] = rsh_s3_r ? (64'(dmag_s3_r[i]) >> amt_s3_r)
                            : (64'(dmag_s3_r[i]) << amt_s3_r);
      qp_nxt[i]  = 64'(abs32(srf_s3_r[i])) * 64'(abs32(t_s3_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_s4_r[i]    <= shw_nxt[i][AW-1:0];
        q_s4_r[i]    <= qp_nxt[i][63:FRAC];
        qsgn_s4_r[i] <= srf_s3_r[i][31] ^ t_s3_r[31];
      end
      dsgn_s4_r  <= dsgn_s3_r;
      black_s4_r <= black_s3_r;
      oc_s4_r    <= oc_s3_r;
      srf_s4_r   <= srf_s3_r;
      typ_s4_r   <= typ_s3_r;
      orgb_s4_r  <= orgb_s3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Squares of the scaled vector; pick the normal by object type.
  logic                v_s5_r;
  logic [2:0][2*AW-1:0] sqr_s5_r;
  logic [2:0][AW-1:0]  a_s5_r;
  logic [2:0][NW-1:0]  n_s5_r;
  logic [2:0]          dsgn_s5_r;
  logic                black_s5_r;
  logic [23:0]         orgb_s5_r;
  logic [2:0][NW-1:0]  n_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (typ_s4_r)
        lds_pkg::OBJ_PLANE:  n_nxt[i] = NW'($signed(srf_s4_r[i]));
        lds_pkg::OBJ_SPHERE: n_nxt[i] = NW'($signed(oc_s4_r[i]));
        lds_pkg::OBJ_CYL:    n_nxt[i] = NW'($signed(oc_s4_r[i]))
                                       - (qsgn_s4_r[i] ? NW'(~NW'(q_s4_r[i]) + NW'(1))
                                                       : NW'(q_s4_r[i]));
        default:             n_nxt[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqr_s5_r[i] <= (2*AW)'(a_s4_r[i]) * (2*AW)'(a_s4_r[i]);
      end
      n_s5_r     <= n_nxt;
      a_s5_r     <= a_s4_r;
      dsgn_s5_r  <= dsgn_s4_r;
      black_s5_r <= black_s4_r;
      orgb_s5_r  <= orgb_s4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Sum of squares; pack what rides along the square root and divider.
  logic               v_s6_r;
  logic [63:0]        sum_s6_r;
  lds_pkg::lds_side_t side_s6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_s6_r        <= 64'(sqr_s5_r[0]) + 64'(sqr_s5_r[1]) + 64'(sqr_s5_r[2]);
      side_s6_r.a     <= a_s5_r;
      side_s6_r.dsgn  <= dsgn_s5_r;
      side_s6_r.n     <= n_s5_r;
      side_s6_r.black <= black_s5_r;
      side_s6_r.orgb  <= orgb_s5_r;
    end
  end

  // ----------------------------------------------- length and unit vector
  logic                   sq_valid;
  logic [lds_pkg::LW-1:0] sq_len;
  lds_pkg::lds_side_t     sq_side;
  logic                   dv_valid;
  logic [2:0][AW-1:0]     dv_u;
  lds_pkg::lds_side_t     dv_side;

  lds_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      ('{adv: adv, valid: v_s6_r}),
    .x_in     (sum_s6_r),
    .side_in  (side_s6_r),
    .out_valid(sq_valid),
    .root_out (sq_len),
    .side_out (sq_side)
  );

  lds_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      ('{adv: adv, valid: sq_valid}),
    .len_in   (sq_len),
    .side_in  (sq_side),
    .out_valid(dv_valid),
    .q_out    (dv_u),
    .side_out (dv_side)
  );

  // ------------------------------------------------------------ post p1
  // |n| and the sign of each n_i * u_i.
  logic                v_p1_r;
  logic [2:0][NW-2:0]  nmag_p1_r;
  logic [2:0]          psg_p1_r;
  logic [2:0][AW-1:0]  u_p1_r;
  logic                black_p1_r;
  logic [23:0]         orgb_p1_r;
  logic [2:0][NW-1:0]  nneg_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nneg_nxt[i] = NW'(~dv_side.n[i] + NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nmag_p1_r[i] <= dv_side.n[i][NW-1] ? nneg_nxt[i][NW-2:0]
                                            : dv_side.n[i][NW-2:0];
        psg_p1_r[i]  <= dv_side.n[i][NW-1] ^ dv_side.dsgn[i];
      end
      u_p1_r     <= dv_u;
      black_p1_r <= dv_side.black;
      orgb_p1_r  <= dv_side.orgb;
    end
  end

  // ------------------------------------------------------------ post p2
  // |n| * u in two partial products.
  logic                  v_p2_r;
  logic [2:0][NL+AW-1:0] pplo_p2_r;
  logic [2:0][NH+AW-1:0] pphi_p2_r;
  logic [2:0]            psg_p2_r;
  logic                  black_p2_r;
  logic [23:0]           orgb_p2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pplo_p2_r[i] <= (NL+AW)'(nmag_p1_r[i][NL-1:0]) * (NL+AW)'(u_p1_r[i]);
        pphi_p2_r[i] <= (NH+AW)'(nmag_p1_r[i][NW-2:NL]) * (NH+AW)'(u_p1_r[i]);
      end
      psg_p2_r   <= psg_p1_r;
      black_p2_r <= black_p1_r;
      orgb_p2_r  <= orgb_p1_r;
    end
  end

  // ------------------------------------------------------------ post p3
  // Join partial products and apply the sign.
  logic                v_p3_r;
  logic [2:0][SW-1:0]  sp_p3_r;
  logic                black_p3_r;
  logic [23:0]         orgb_p3_r;
  logic [2:0][SW-1:0]  pr_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i] = (SW'(pphi_p2_r[i]) << NL) + SW'(pplo_p2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sp_p3_r[i] <= psg_p2_r[i] ? SW'(~pr_nxt[i] + SW'(1)) : pr_nxt[i];
      end
      black_p3_r <= black_p2_r;
      orgb_p3_r  <= orgb_p2_r;
    end
  end

  // ------------------------------------------------------------ post p4
  // Exact dot product; facing away (dot <= 0) turns black.
  logic            v_p4_r;
  logic [DW-1:0]   dpos_p4_r;
  logic            black_p4_r;
  logic [23:0]     orgb_p4_r;
  logic [SW-1:0]   dot_nxt;

  assign dot_nxt = sp_p3_r[0] + sp_p3_r[1] + sp_p3_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      dpos_p4_r  <= dot_nxt[DW-1:0];
      black_p4_r <= black_p3_r || dot_nxt[SW-1] || (dot_nxt == '0);
      orgb_p4_r  <= orgb_p3_r;
    end
  end

  // ------------------------------------------------------------ post p5
  // Dot * brightness in three slices.
  logic              v_p5_r;
  logic [48:0]       b0_p5_r, b1_p5_r;
  logic [DW-64+16:0] b2_p5_r;
  logic              black_p5_r;
  logic [23:0]       orgb_p5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_p5_r    <= 49'(dpos_p4_r[31:0]) * 49'(bright_r);
      b1_p5_r    <= 49'(dpos_p4_r[63:32]) * 49'(bright_r);
      b2_p5_r    <= (DW-64+17)'(dpos_p4_r[DW-1:64]) * (DW-64+17)'(bright_r);
      black_p5_r <= black_p4_r;
      orgb_p5_r  <= orgb_p4_r;
    end
  end

  // ------------------------------------------------------------ post p6
  // Intensity in Q.32, saturation flag, per channel colour products.
  logic              v_p6_r;
  logic [IW-1:0]     il_p6_r;
  logic              sat_p6_r;
  logic [2:0][15:0]  prodc_p6_r;
  logic              black_p6_r;
  logic [BW-1:0]     bp_nxt;

  assign bp_nxt = BW'(b0_p5_r) + (BW'(b1_p5_r) << 32) + (BW'(b2_p5_r) << 64);

  always_ff @(posedge clk) begin
    if (adv) begin
      il_p6_r    <= bp_nxt[IS+IW-1:IS];
      sat_p6_r   <= |bp_nxt[BW-1:IS+IW];
      for (int i = 0; i < 3; i++) begin
        prodc_p6_r[i] <= 16'(orgb_p5_r[23-8*i -: 8]) * 16'(lrgb_r[23-8*i -: 8]);
      end
      black_p6_r <= black_p5_r;
    end
  end

  // ------------------------------------------------------------ post p7
  logic             v_p7_r;
  logic [2:0][31:0] w_p7_r;
  logic [2:0]       pnz_p7_r;
  logic             sat_p7_r;
  logic             black_p7_r;
  logic [2:0][63:0] x_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_nxt[i] = 64'(prodc_p6_r[i]) * 64'(il_p6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w_p7_r[i]   <= x_nxt[i][63:32];
        pnz_p7_r[i] <= prodc_p6_r[i] != '0;
      end
      sat_p7_r   <= sat_p6_r;
      black_p7_r <= black_p6_r;
    end
  end

  // ------------------------------------------------------------ post p8
  // Divide by 255 through the reciprocal; flag values that clip.
  logic             v_p8_r;
  logic [2:0]       big_p8_r;
  logic [2:0][31:0] m_p8_r;
  logic [2:0]       pnz_p8_r;
  logic             sat_p8_r;
  logic             black_p8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        big_p8_r[i] <= w_p7_r[i] >= lds_pkg::CLIP_LIMIT;
        m_p8_r[i]   <= 32'(w_p7_r[i][15:0]) * 32'(lds_pkg::DIV255_MUL);
      end
      pnz_p8_r   <= pnz_p7_r;
      sat_p8_r   <= sat_p7_r;
      black_p8_r <= black_p7_r;
    end
  end

  // ------------------------------------------------------------ output
  logic [2:0][7:0] rgb_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (black_p8_r)       rgb_out_r[i] <= 8'd0;
        else if (sat_p8_r)    rgb_out_r[i] <= pnz_p8_r[i] ? 8'd255 : 8'd0;
        else if (big_p8_r[i]) rgb_out_r[i] <= 8'd255;
        else rgb_out_r[i] <= m_p8_r[i][lds_pkg::DIV255_SH+7:lds_pkg::DIV255_SH];
      end
    end
  end

  // Valid bits travel with the words; hold everything while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0; v_s2_r <= 1'b0; v_s3_r <= 1'b0;
      v_s4_r <= 1'b0; v_s5_r <= 1'b0; v_s6_r <= 1'b0;
      v_p1_r <= 1'b0; v_p2_r <= 1'b0; v_p3_r <= 1'b0; v_p4_r <= 1'b0;
      v_p5_r <= 1'b0; v_p6_r <= 1'b0; v_p7_r <= 1'b0; v_p8_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_s1_r <= in_ch.valid;
      v_s2_r <= v_s1_r; v_s3_r <= v_s2_r; v_s4_r <= v_s3_r;
      v_s5_r <= v_s4_r; v_s6_r <= v_s5_r;
      v_p1_r <= dv_valid;
      v_p2_r <= v_p1_r; v_p3_r <= v_p2_r; v_p4_r <= v_p3_r;
      v_p5_r <= v_p4_r; v_p6_r <= v_p5_r; v_p7_r <= v_p6_r; v_p8_r <= v_p7_r;
      out_valid_r <= v_p8_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = rgb_out_r[0];
  assign out_ch.green = rgb_out_r[1];
  assign out_ch.blue  = rgb_out_r[2];

endmodule

[rtl/core/lds_checker.sv]
module lds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // reset empties the pipeline
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a held result freezes the whole pipeline
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline stalled");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(red) && $stable(green) && $stable(blue)))
    else $error("stalled result word changed");

endmodule

bind lambert_diffuse_shader lds_checker u_lds_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .red      (out_ch.red),
  .green    (out_ch.green),
  .blue     (out_ch.blue)
);

[dv/lds_tb_if.sv]
`timescale 1ns / 100ps

// Channel bundles come from the block's own interface files; this file only
// holds the hit word and colour types used by the driver and the predictor.
package lds_tb_pkg;
  import lds_pkg::*;

  typedef struct {
    lds_obj_t        kind;
    logic [23:0]     orgb;
    logic signed [31:0] hit [3];
    logic signed [31:0] cen [3];
    logic signed [31:0] srf [3];
  } hit_word_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } colour_t;
endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lds_pkg::*;
  import lds_tb_pkg::*;

  logic clk;
  logic rst_n;

  lds_in_if  in_ch ();
  lds_out_if out_ch ();
  lds_cfg_if cfg_ch ();

  lambert_diffuse_shader uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Shadow copy of the light registers
  logic signed [31:0] lamp_pos [3];
  logic [16:0]        lamp_bright;
  logic [23:0]        lamp_rgb;

  hit_word_t hit_queue [$];
  colour_t   colour_queue [$];
  int        fail_count;
  int        cycle_count;
  bit        calm;       // no idling in the last part
  bit        hold_send;  // driver pauses while set
  bit        in_fire;    // input word taken at the last rising edge
  int        send_gap;
  int        take_gap;
  localparam int LATENCY = 78;
  localparam int CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Truncate toward zero on a right shift
  function automatic longint trunc_shr(input longint v, input int k);
    longint unsigned m;
    m = magn(v) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Diffuse colour of one hit under the current light setting
  function automatic colour_t shade_hit(input hit_word_t w);
    colour_t c;
    longint d [3];
    longint u [3];
    longint nrm [3];
    longint oc [3];
    longint t;
    longint unsigned m;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned p;
    logic signed [127:0] dot;
    logic [127:0] inten;
    logic [127:0] v;
    logic [15:0] prod;
    int sh;
    c = '{8'd0, 8'd0, 8'd0};
    m = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(lamp_pos[i]) - longint'(w.hit[i]);
      if (magn(d[i]) > m) m = magn(d[i]);
    end
    if (m == 0 || w.kind == OBJ_UNKNOWN) return c;
    while (m >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) d[i] = trunc_shr(d[i], 1);
      m >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) d[i] = d[i] * 2;
      m <<= 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += magn(d[i]) * magn(d[i]);
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      p = (magn(d[i]) << 30) / len;
      u[i] = d[i] < 0 ? -longint'(p) : longint'(p);
    end
    for (int i = 0; i < 3; i++) oc[i] = longint'(w.hit[i]) - longint'(w.cen[i]);
    case (w.kind)
      OBJ_PLANE: begin
        for (int i = 0; i < 3; i++) nrm[i] = w.srf[i];
      end
      OBJ_SPHERE: begin
        for (int i = 0; i < 3; i++) nrm[i] = oc[i];
      end
      default: begin
        t = 0;
        for (int i = 0; i < 3; i++) begin
          p = (magn(oc[i]) * magn(w.srf[i])) >> FRAC;
          t += ((oc[i] < 0) != (w.srf[i] < 0)) ? -longint'(p) : longint'(p);
        end
        if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
        if (t < -64'sh80000000) t = -64'sh80000000;
        for (int i = 0; i < 3; i++)
          nrm[i] = oc[i] - trunc_shr(longint'(w.srf[i]) * t, FRAC);
      end
    endcase
    dot = 0;
    for (int i = 0; i < 3; i++)
      dot += 128'(signed'(nrm[i])) * 128'(signed'(u[i]));
    // Facing away or edge on gives black
    if (dot <= 0) return c;
    inten = (128'(dot) * 128'(lamp_bright)) >> (FRAC + 14);
    for (int i = 0; i < 3; i++) begin
      sh = 16 - 8 * i;
      prod = 16'((w.orgb >> sh) & 8'hFF) * 16'((lamp_rgb >> sh) & 8'hFF);
      if (inten >= (128'd1 << 48)) begin
        v = prod != 0 ? 128'd255 : 128'd0;
      end else begin
        v = (128'(prod) * inten) / (128'd255 << 32);
        if (v > 255) v = 255;
      end
      if (i == 0) c.r = v[7:0];
      else if (i == 1) c.g = v[7:0];
      else c.b = v[7:0];
    end
    return c;
  endfunction

  // Driver: present queued hit words, idle in bursts, change on falling edge
  always @(negedge clk) begin
    if (in_ch.valid && in_ch.ready && rst_n) begin
      // word went in at the last rising edge; predictor ran there
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the word until it is taken
    end else if (send_gap > 0) begin
      send_gap    <= send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (hold_send || hit_queue.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap    <= $urandom_range(0, 4);
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid       <= 1'b1;
      in_ch.object_type <= hit_queue[0].kind;
      in_ch.object_rgb  <= hit_queue[0].orgb;
      in_ch.hit_x <= hit_queue[0].hit[0];
      in_ch.hit_y <= hit_queue[0].hit[1];
      in_ch.hit_z <= hit_queue[0].hit[2];
      in_ch.center_x <= hit_queue[0].cen[0];
      in_ch.center_y <= hit_queue[0].cen[1];
      in_ch.center_z <= hit_queue[0].cen[2];
      in_ch.surface_x <= hit_queue[0].srf[0];
      in_ch.surface_y <= hit_queue[0].srf[1];
      in_ch.surface_z <= hit_queue[0].srf[2];
      void'(hit_queue.pop_front());
    end
  end

  // Sink side back-pressure, also in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap     <= take_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      take_gap     <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    hit_word_t w;
    colour_t exp_c;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_ch.valid && in_ch.ready) begin
        w.kind = lds_obj_t'(in_ch.object_type);
        w.orgb = in_ch.object_rgb;
        w.hit = '{in_ch.hit_x, in_ch.hit_y, in_ch.hit_z};
        w.cen = '{in_ch.center_x, in_ch.center_y, in_ch.center_z};
        w.srf = '{in_ch.surface_x, in_ch.surface_y, in_ch.surface_z};
        colour_queue.push_back(shade_hit(w));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (colour_queue.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          exp_c = colour_queue.pop_front();
          if (out_ch.red !== exp_c.r) begin
            $error("red: expected %0d, got %0d", exp_c.r, out_ch.red);
            fail_count++;
          end
          if (out_ch.green !== exp_c.g) begin
            $error("green: expected %0d, got %0d", exp_c.g, out_ch.green);
            fail_count++;
          end
          if (out_ch.blue !== exp_c.b) begin
            $error("blue: expected %0d, got %0d", exp_c.b, out_ch.blue);
            fail_count++;
          end
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write one light register while the pipe is empty
  task automatic write_reg(input lds_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_LIGHT_X: lamp_pos[0] = data;
      REG_LIGHT_Y: lamp_pos[1] = data;
      REG_LIGHT_Z: lamp_pos[2] = data;
      REG_BRIGHT:  lamp_bright = data[16:0];
      REG_RGB:     lamp_rgb    = data[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued word has gone in and come back out
  task automatic drain();
    while (hit_queue.size() != 0 || in_ch.valid || colour_queue.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input bit near);
    if (near) return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
    return $urandom();
  endfunction

  // Unit-ish axis or normal in Q16.16, sometimes arbitrary
  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  task automatic queue_hit(input lds_obj_t k, input logic [23:0] rgb,
                           input logic [31:0] h [3], input logic [31:0] c [3],
                           input logic [31:0] s [3]);
    hit_word_t w;
    w.kind = k;
    w.orgb = rgb;
    for (int i = 0; i < 3; i++) begin
      w.hit[i] = h[i];
      w.cen[i] = c[i];
      w.srf[i] = s[i];
    end
    hit_queue.push_back(w);
  endtask

  task automatic queue_random(input int count);
    logic [31:0] h [3];
    logic [31:0] c [3];
    logic [31:0] s [3];
    bit near;
    for (int n = 0; n < count; n++) begin
      near = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 3; i++) begin
        h[i] = rand_coord(near);
        c[i] = near ? h[i] + rand_coord(1) : $urandom();
        s[i] = rand_dir();
      end
      queue_hit(lds_obj_t'($urandom_range(0, 3)),
                $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom()), h, c, s);
    end
  endtask

  initial begin
    logic [31:0] h [3];
    logic [31:0] c [3];
    logic [31:0] s [3];
    fail_count = 0;
    cycle_count = 0;
    calm = 0;
    hold_send = 0;
    in_fire = 0;
    send_gap = 0;
    take_gap = 0;
    lamp_pos = '{32'sd0, 32'sd0, 32'sd0};
    lamp_bright = BRIGHT_RESET;
    lamp_rgb = RGB_RESET;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.object_type = OBJ_PLANE;
    in_ch.object_rgb = '0;
    in_ch.hit_x = '0; in_ch.hit_y = '0; in_ch.hit_z = '0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.center_z = '0;
    in_ch.surface_x = '0; in_ch.surface_y = '0; in_ch.surface_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LIGHT_X;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset light (at origin, full white)
    s = '{32'sd0, 32'sd0, -32'sd65536};
    h = '{32'sd0, 32'sd0, 32'sd0};
    c = '{32'sd0, 32'sd0, 32'sd0};
    queue_hit(OBJ_PLANE, 24'hFFFFFF, h, c, s);           // light on the hit
    h = '{32'sd0, 32'sd0, 32'sd65536};
    queue_hit(OBJ_PLANE, 24'hFFFFFF, h, c, s);           // facing the light
    queue_hit(OBJ_UNKNOWN, 24'hFFFFFF, h, c, s);         // unknown type
    s = '{32'sd0, 32'sd0, 32'sd65536};
    queue_hit(OBJ_PLANE, 24'hFFFFFF, h, c, s);           // facing away
    queue_hit(OBJ_PLANE, 24'h000000, h, c, '{32'sd0, 32'sd0, -32'sh7FFFFFFF});
    // huge intensity from a long normal
    queue_hit(OBJ_PLANE, 24'h80FF01, h, c, '{32'sd0, 32'sd0, 32'sh80000000});
    h = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    c = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
    queue_hit(OBJ_SPHERE, 24'hFFFFFF, h, c, s);
    queue_hit(OBJ_CYL, 24'hFFFFFF, h, c, '{32'sh7FFFFFFF, 32'sh80000000, 32'sd1});
    h = '{32'sd65536, 32'sd0, 32'sd131072};
    c = '{32'sd0, 32'sd0, 32'sd0};
    queue_hit(OBJ_CYL, 24'h123456, h, c, '{32'sd0, 32'sd0, 32'sd65536});
    queue_hit(OBJ_CYL, 24'hABCDEF, h, c, '{32'sd200000, 32'sd0, 32'sd0});
    queue_hit(OBJ_SPHERE, 24'hFEDCBA, '{-32'sd65536, 32'sd0, 32'sd0}, c, s);
    drain();

    // Sweep through light settings, extremes among them
    write_reg(REG_LIGHT_X, 32'h7FFFFFFF);
    write_reg(REG_LIGHT_Y, 32'h80000000);
    write_reg(REG_LIGHT_Z, 32'h7FFFFFFF);
    write_reg(REG_BRIGHT, 32'd0);
    write_reg(REG_RGB, 32'h000000);
    queue_random(60);
    drain();
    write_reg(REG_BRIGHT, 32'h1FFFF);
    write_reg(REG_RGB, 32'hFFFFFF);
    write_reg(REG_LIGHT_X, 32'h80000000);
    queue_random(150);
    // pause the sender until everything is back
    while (hit_queue.size() != 0 || in_ch.valid) @(posedge clk);
    hold_send = 1;
    queue_random(100);
    while (colour_queue.size() != 0) @(posedge clk);
    hold_send = 0;
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      write_reg(REG_LIGHT_X, 32'($signed($urandom_range(0, 1310720)) - 655360));
      write_reg(REG_LIGHT_Y, 32'($signed($urandom_range(0, 1310720)) - 655360));
      write_reg(REG_LIGHT_Z, 32'($signed($urandom_range(0, 1310720)) - 655360));
      write_reg(REG_BRIGHT, $urandom_range(0, 65536));
      write_reg(REG_RGB, $urandom());
      if (phase == 2) calm = 1;
      queue_random(160);
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/lds_pkg.sv
rtl/core/lds_in_if.sv
rtl/core/lds_out_if.sv
rtl/core/lds_cfg_if.sv
rtl/core/lds_isqrt.sv
rtl/core/lds_div3.sv
rtl/core/lambert_diffuse_shader.sv
rtl/core/lds_checker.sv
dv/lds_tb_if.sv
dv/tb_top.sv
